@@ hw/rtl/frtl_pkg.sv @@
// Shared types and constants of the flow route table lookup block.
package frtl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int PORT_W  = 8;
    localparam int FLOW_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam logic [PORT_W-1:0] WC_PORT_RST = '1;
    localparam logic [FLOW_W-1:0] WC_FLOW_RST = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_PORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_FLOW = 1'b1;

    // Command codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NO_PORT = 3'd2,
        ST_NO_FLOW = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Input transaction payload
    typedef struct packed {
        logic              opcode;
        logic [PORT_W-1:0] in_port;
        logic [FLOW_W-1:0] flow_key;
        logic [PORT_W-1:0] route_port;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        t_status           status;
    } t_out;

    // Classified command queued between front and engine
    typedef struct packed {
        t_op               op;
        logic [PORT_W-1:0] in_port;
        logic [FLOW_W-1:0] flow_key;
        logic [PORT_W-1:0] route_port;
    } t_cmd;

    // One table slot
    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] in_port;
        logic [FLOW_W-1:0] flow;
        logic [PORT_W-1:0] out_port;
    } t_entry;

endpackage

@@ hw/rtl/frtl_front.sv @@
// Front end: accepts input transactions, decodes them and queues commands.
module frtl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  frtl_pkg::t_in   i_in,
    output logic            o_in_stall,
    input  logic            i_clearing,
    input  logic            i_pop,
    output logic            o_q_valid,
    output frtl_pkg::t_cmd  o_q_cmd
);
    import frtl_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       push;
    logic       pop;
    t_cmd       dec_cmd;

    // Decode the opcode into a command
    always_comb begin
        dec_cmd.op         = i_in.opcode ? OP_LOOKUP : OP_INSERT;
        dec_cmd.in_port    = i_in.in_port;
        dec_cmd.flow_key   = i_in.flow_key;
        dec_cmd.route_port = i_in.route_port;
    end

    // Hold off new transactions while full or while the table is being cleared
    assign o_in_stall = (r_count == 2'd2) || i_clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && o_q_valid;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_cmd    = r_slot[r_rd_ptr];

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

@@ hw/rtl/frtl_engine.sv @@
// Back end: table storage, sequential scan, insert/lookup resolution, output register.
module frtl_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [frtl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [frtl_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_q_valid,
    input  frtl_pkg::t_cmd                     i_q_cmd,
    output logic                               o_pop,
    output logic                               o_clearing,
    output logic                               o_out_valid,
    output frtl_pkg::t_out                     o_out,
    input  logic                               i_out_stall
);
    import frtl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Table memory
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_mem_q;

    t_state            r_state;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    t_cmd              r_cmd;
    logic [PORT_W-1:0] r_wc_port;
    logic [FLOW_W-1:0] r_wc_flow;

    // Scan results
    logic              r_any;
    logic              r_grp_ex;
    logic              r_grp_wc;
    logic              r_hit_exex;
    logic              r_hit_exwf;
    logic              r_hit_wcex;
    logic              r_hit_wcwf;
    logic [PORT_W-1:0] r_port_exex;
    logic [PORT_W-1:0] r_port_exwf;
    logic [PORT_W-1:0] r_port_wcex;
    logic [PORT_W-1:0] r_port_wcwf;
    logic [IDX_W-1:0]  r_match_idx;
    logic              r_free;
    logic [IDX_W-1:0]  r_free_idx;

    logic              r_out_valid;
    t_out              r_out;

    // Per-entry compares
    logic              e_port_ex;
    logic              e_port_wc;
    logic              e_flow_ex;
    logic              e_flow_wc;

    // Memory write port
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;

    // Result decision
    logic              load_out;
    t_out              res;
    logic              ins_we;
    logic [IDX_W-1:0]  ins_idx;

    assign e_port_ex = r_mem_q.valid && (r_mem_q.in_port == r_cmd.in_port);
    assign e_port_wc = r_mem_q.valid && (r_mem_q.in_port == r_wc_port);
    assign e_flow_ex = (r_mem_q.flow == r_cmd.flow_key);
    assign e_flow_wc = (r_mem_q.flow == r_wc_flow);

    assign load_out = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    // Resolve the finished scan into a result and, for inserts, a slot write
    always_comb begin
        res.out_port = '0;
        res.status   = ST_OK;
        ins_we       = 1'b0;
        ins_idx      = r_match_idx;
        if (r_cmd.op == OP_INSERT) begin
            if (r_hit_exex) begin
                ins_we  = 1'b1;
                ins_idx = r_match_idx;
            end else if (r_free) begin
                ins_we  = 1'b1;
                ins_idx = r_free_idx;
            end else begin
                res.status = ST_FULL;
            end
        end else begin
            priority if (!r_any) begin
                res.status = ST_EMPTY;
            end else if (r_grp_ex) begin
                priority if (r_hit_exex) begin
                    res.out_port = r_port_exex;
                end else if (r_hit_exwf) begin
                    res.out_port = r_port_exwf;
                end else begin
                    res.status = ST_NO_FLOW;
                end
            end else if (r_grp_wc) begin
                priority if (r_hit_wcex) begin
                    res.out_port = r_port_wcex;
                end else if (r_hit_wcwf) begin
                    res.out_port = r_port_wcwf;
                end else begin
                    res.status = ST_NO_FLOW;
                end
            end else begin
                res.status = ST_NO_PORT;
            end
        end
    end

    // Memory write mux: clearing sweep or insert commit
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (load_out && ins_we) begin
            mem_we              = 1'b1;
            mem_waddr           = ins_idx;
            mem_wdata.valid     = 1'b1;
            mem_wdata.in_port   = r_cmd.in_port;
            mem_wdata.flow      = r_cmd.flow_key;
            mem_wdata.out_port  = r_cmd.route_port;
        end
    end

    // Table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[r_addr];
    end

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer, scan accumulators, config registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_wc_port   <= WC_PORT_RST;
            r_wc_flow   <= WC_FLOW_RST;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WILDCARD_PORT: r_wc_port <= i_cfg_data[PORT_W-1:0];
                    CFG_WILDCARD_FLOW: r_wc_flow <= i_cfg_data[FLOW_W-1:0];
                    default:           r_wc_port <= r_wc_port;
                endcase
            end

            // Output slot
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Accumulate one entry per cycle, in the cycle after its read address
            if (r_rd_vld) begin
                if (r_mem_q.valid) begin
                    r_any <= 1'b1;
                end
                if (e_port_ex) begin
                    r_grp_ex <= 1'b1;
                end
                if (e_port_wc) begin
                    r_grp_wc <= 1'b1;
                end
                if (e_port_ex && e_flow_ex && !r_hit_exex) begin
                    r_hit_exex  <= 1'b1;
                    r_port_exex <= r_mem_q.out_port;
                    r_match_idx <= r_rd_idx;
                end
                if (e_port_ex && e_flow_wc && !r_hit_exwf) begin
                    r_hit_exwf  <= 1'b1;
                    r_port_exwf <= r_mem_q.out_port;
                end
                if (e_port_wc && e_flow_ex && !r_hit_wcex) begin
                    r_hit_wcex  <= 1'b1;
                    r_port_wcex <= r_mem_q.out_port;
                end
                if (e_port_wc && e_flow_wc && !r_hit_wcwf) begin
                    r_hit_wcwf  <= 1'b1;
                    r_port_wcwf <= r_mem_q.out_port;
                end
                if (!r_mem_q.valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + IDX_W'(1);
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd      <= i_q_cmd;
                        r_addr     <= '0;
                        r_any      <= 1'b0;
                        r_grp_ex   <= 1'b0;
                        r_grp_wc   <= 1'b0;
                        r_hit_exex <= 1'b0;
                        r_hit_exwf <= 1'b0;
                        r_hit_wcex <= 1'b0;
                        r_hit_wcwf <= 1'b0;
                        r_free     <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_addr;
                    r_addr   <= (r_addr == LAST_IDX) ? '0 : r_addr + IDX_W'(1);
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= S_RESULT;
                end
                S_RESULT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/flow_route_table_lookup.sv @@
// Top level of the flow route table lookup block.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in   (t_in)
//  out       output     o_out_valid / i_out_stall o_out  (t_out)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Each transaction scans the whole table through the single memory read port,
//  one slot per cycle. After reset a clearing pass marks every slot free; the
//  input is stalled during it, config writes are taken at all times.
//  A two-entry command queue lets the front accept while the engine scans, and
//  a full output register lets the next scan run while a result waits.
module flow_route_table_lookup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  frtl_pkg::t_in                  i_in,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output frtl_pkg::t_out                 o_out,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [frtl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [frtl_pkg::CFG_W-1:0]     i_cfg_data
);
    import frtl_pkg::*;

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    logic clearing;

    // Config registers take a write every cycle
    assign o_cfg_ready = 1'b1;

    frtl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_clearing (clearing),
        .i_pop      (q_pop),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd)
    );

    frtl_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ dv/flow_route_table_lookup_check.sv @@
`timescale 1ns / 100ps
// Scoreboard for the flow route table lookup: mirrors the table, predicts and checks every result.
module flow_route_table_lookup_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  frtl_pkg::t_in                  i_in,
    input  logic                           i_in_stall,
    input  logic                           i_out_valid,
    input  frtl_pkg::t_out                 i_out,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [frtl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [frtl_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_err_cnt,
    output int                             o_pending,
    output int                             o_checked
);
    import frtl_pkg::*;

    // Mirror of the routing table and the wildcard registers
    t_entry            route_tbl [TABLE_DEPTH];
    logic [PORT_W-1:0] wc_port;
    logic [FLOW_W-1:0] wc_flow;

    // Results owed by the block, oldest first
    t_out              route_results_q [$];
    t_out              owed;
    int                mism_cnt;
    int                chk_cnt;

    // Slot holding this exact port/flow pair, -1 if none
    function automatic int slot_of(input logic [PORT_W-1:0] port,
                                   input logic [FLOW_W-1:0] flow);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (route_tbl[i].valid && route_tbl[i].in_port == port &&
                route_tbl[i].flow == flow)
                return i;
        return -1;
    endfunction

    function automatic logic group_present(input logic [PORT_W-1:0] port);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (route_tbl[i].valid && route_tbl[i].in_port == port)
                return 1'b1;
        return 1'b0;
    endfunction

    // Applies one command to the mirror table and returns the result it owes
    function automatic t_out route_predict(input t_in cmd);
        t_out              res;
        int                slot;
        logic              any_valid;
        logic [PORT_W-1:0] grp;
        res.out_port = '0;
        res.status   = ST_OK;
        if (cmd.opcode == OP_INSERT) begin
            // overwrite a matching entry, else take the lowest free slot
            slot = slot_of(cmd.in_port, cmd.flow_key);
            for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
                if (!route_tbl[i].valid)
                    slot = i;
            if (slot < 0) begin
                res.status = ST_FULL;
            end else begin
                route_tbl[slot].valid    = 1'b1;
                route_tbl[slot].in_port  = cmd.in_port;
                route_tbl[slot].flow     = cmd.flow_key;
                route_tbl[slot].out_port = cmd.route_port;
            end
        end else begin
            any_valid = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                any_valid |= route_tbl[i].valid;
            // exact port group first, wildcard port group otherwise
            grp = group_present(cmd.in_port) ? cmd.in_port : wc_port;
            if (!any_valid) begin
                res.status = ST_EMPTY;
            end else if (!group_present(grp)) begin
                res.status = ST_NO_PORT;
            end else begin
                slot = slot_of(grp, cmd.flow_key);
                if (slot < 0)
                    slot = slot_of(grp, wc_flow);
                if (slot < 0)
                    res.status = ST_NO_FLOW;
                else
                    res.out_port = route_tbl[slot].out_port;
            end
        end
        return res;
    endfunction

    // Watch all three channels; results are retired before new commands are predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                route_tbl[i] = '0;
            wc_port  = WC_PORT_RST;
            wc_flow  = WC_FLOW_RST;
            route_results_q.delete();
            mism_cnt = 0;
            chk_cnt  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WILDCARD_PORT)
                    wc_port = i_cfg_data[PORT_W-1:0];
                else if (i_cfg_index == CFG_WILDCARD_FLOW)
                    wc_flow = i_cfg_data[FLOW_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                chk_cnt++;
                if (route_results_q.size() == 0) begin
                    if (mism_cnt < 10)
                        $display("[%0t] unexpected result transaction: out_port %0d status %0d",
                                 $time, i_out.out_port, i_out.status);
                    mism_cnt++;
                end else begin
                    owed = route_results_q.pop_front();
                    if (i_out.out_port !== owed.out_port || i_out.status !== owed.status) begin
                        if (mism_cnt < 10)
                            $display({"[%0t] mismatch: out_port exp %0d got %0d, ",
                                      "status exp %0d got %0d"},
                                     $time, owed.out_port, i_out.out_port, owed.status,
                                     i_out.status);
                        mism_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                route_results_q.push_back(route_predict(i_in));
        end
        o_err_cnt <= mism_cnt;
        o_pending <= route_results_q.size();
        o_checked <= chk_cnt;
    end

endmodule

@@ dv/flow_route_table_lookup_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the flow route table lookup: stimulus, idling, watchdog and verdict.
module flow_route_table_lookup_test;
    import frtl_pkg::*;

    localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 4);
    localparam int WDOG_LIMIT    = 20000;
    localparam int PHASE_ITEMS   = 600;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in                  in_data   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out                 out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int                   chk_err;
    int                   chk_pending;
    int                   chk_checked;

    int                   send_idle = 0;
    int                   recv_idle = 0;
    logic [PORT_W-1:0]    cur_wc_port = WC_PORT_RST;
    logic [FLOW_W-1:0]    cur_wc_flow = WC_FLOW_RST;
    int                   n_insert = 0;
    int                   n_lookup = 0;
    int                   n_cfg    = 0;
    int                   wdog     = 0;

    always #2 clk = ~clk;

    flow_route_table_lookup u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    flow_route_table_lookup_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_data),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out       (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_err_cnt   (chk_err),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked)
    );

    // Receiver back-pressure
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < recv_idle);
    end

    // Watchdog: cycles in a row with no transaction on any channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired: no transaction for %0d cycles, %0d results owed",
                     wdog, chk_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one command, with random idle cycles ahead of it; returns at acceptance
    task automatic push_cmd(input t_in cmd);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd.opcode == OP_INSERT)
            n_insert++;
        else
            n_lookup++;
    endtask

    task automatic issue(input t_op op, input logic [PORT_W-1:0] port,
                         input logic [FLOW_W-1:0] flow, input logic [PORT_W-1:0] route);
        t_in cmd;
        cmd.opcode     = op;
        cmd.in_port    = port;
        cmd.flow_key   = flow;
        cmd.route_port = route;
        push_cmd(cmd);
    endtask

    // Sender goes quiet until every owed result has been taken
    task automatic hold_until_empty();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
    endtask

    task automatic drain_all();
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; port writes carry random upper bits that the block must drop
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (idx == CFG_WILDCARD_PORT) ? (($urandom() & 32'hFFFF_FF00) | val) : val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_WILDCARD_PORT)
            cur_wc_port = val[PORT_W-1:0];
        else
            cur_wc_flow = val;
        n_cfg++;
    endtask

    // Commands biased toward a small key space so lookups hit and inserts overwrite
    function automatic t_in random_cmd();
        t_in cmd;
        int  pick;
        cmd.opcode = ($urandom_range(99) < 35) ? OP_INSERT : OP_LOOKUP;
        pick = $urandom_range(99);
        if (pick < 80)
            cmd.in_port = PORT_W'($urandom_range(7));
        else if (pick < 90)
            cmd.in_port = cur_wc_port;
        else
            cmd.in_port = PORT_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 50)
            cmd.flow_key = $urandom_range(7);
        else if (pick < 70)
            cmd.flow_key = cur_wc_flow;
        else if (pick < 78)
            cmd.flow_key = '1;
        else
            cmd.flow_key = $urandom();
        cmd.route_port = PORT_W'($urandom_range(255));
        return cmd;
    endfunction

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) begin
            if (k == n / 2)
                hold_until_empty();
            push_cmd(random_cmd());
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: defaults, then every lookup outcome and overwrite
        send_idle = 30;
        recv_idle = 50;
        write_reg(CFG_WILDCARD_PORT, 32'h0000_00FF);
        write_reg(CFG_WILDCARD_FLOW, 32'hFFFF_FFFF);
        issue(OP_LOOKUP, 8'd0,   32'h0,         8'hFF);  // empty table
        issue(OP_INSERT, 8'd0,   32'h0,         8'h00);
        issue(OP_INSERT, 8'd0,   32'hFFFF_FFFF, 8'hFF);  // wildcard flow in group 0
        issue(OP_LOOKUP, 8'd0,   32'h0,         8'h00);  // exact hit
        issue(OP_LOOKUP, 8'd0,   32'h0000_3039, 8'hFF);  // falls back to wildcard flow
        issue(OP_LOOKUP, 8'd7,   32'h0,         8'h00);  // unknown port, no wildcard group
        issue(OP_INSERT, 8'd7,   32'h5555_5555, 8'hAA);
        issue(OP_LOOKUP, 8'd7,   32'h0,         8'hFF);  // unknown flow, no wildcard flow
        issue(OP_INSERT, 8'd0,   32'h0,         8'h5A);  // overwrite
        issue(OP_LOOKUP, 8'd0,   32'h0,         8'h00);
        issue(OP_INSERT, 8'd255, 32'hAAAA_AAAA, 8'h33);  // wildcard port group
        issue(OP_LOOKUP, 8'd9,   32'hAAAA_AAAA, 8'hFF);  // hit through wildcard port
        issue(OP_LOOKUP, 8'd9,   32'h1,         8'h00);  // wildcard group, flow unknown
        issue(OP_LOOKUP, 8'd255, 32'hAAAA_AAAA, 8'hFF);  // query port is the wildcard
        issue(OP_INSERT, 8'd255, 32'hFFFF_FFFF, 8'hC3);
        issue(OP_LOOKUP, 8'd9,   32'h2,         8'h00);  // both wildcards
        issue(OP_LOOKUP, 8'd7,   32'h5555_5555, 8'hFF);
        drain_all();

        // Low wildcard values; sender idles less than the receiver
        write_reg(CFG_WILDCARD_PORT, 32'h0);
        write_reg(CFG_WILDCARD_FLOW, 32'h0);
        random_phase(PHASE_ITEMS);
        drain_all();

        // Random wildcard values; receiver idles less than the sender
        send_idle = 50;
        recv_idle = 30;
        write_reg(CFG_WILDCARD_PORT, $urandom_range(254, 8));
        write_reg(CFG_WILDCARD_FLOW, ($urandom_range(1) != 0) ? $urandom() : $urandom_range(7));
        random_phase(PHASE_ITEMS);
        drain_all();

        // High wildcard values at full rate
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_WILDCARD_PORT, 32'h0000_00FF);
        write_reg(CFG_WILDCARD_FLOW, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);
        drain_all();

        $display({"Covered %0d inserts and %0d lookups under %0d register writes ",
                  "(three wildcard settings),"},
                 n_insert, n_lookup, n_cfg);
        $display({"%0d results checked with sender and receiver idling, ",
                  "back-pressure and a full table."},
                 chk_checked);
        if (chk_err == 0 && chk_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
